// ===== rtl/core/rlcd_pkg.sv =====
// shared types and constants for the zero-run / literal run-length decoder
package rlcd_pkg;

    localparam int unsigned CodeW  = 8;
    localparam int unsigned CountW = 16;
    localparam int unsigned LitW   = 6;

    localparam logic [CountW-1:0] LimitReset = 16'hFFFF;

    // control byte fields
    localparam int unsigned CtlLongBit  = 7;
    localparam int unsigned CtlShortBit = 6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start_item;   // word accepted this cycle
        logic emit_lit;     // copy the word out as a literal
        logic set_err;      // malformed control byte
        logic take_ctrl;    // load literal and zero counts from control byte
        logic emit_zero;    // emit one zero fill byte
    } rlcd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic can_load;     // output register free or draining
        logic blocked;      // record at its limit
        logic lit_pending;  // word is a literal
        logic bad_ctrl;     // control byte with low seven bits zero
        logic zero_run;     // control byte asks for zeros
        logic run_end;      // current zero is the last of the run
    } rlcd_sts_t;

endpackage

// ===== rtl/core/rlcd_ctrl.sv =====
// controller state machine for the run-length decoder
module rlcd_ctrl
    import rlcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rlcd_sts_t sts,
    output rlcd_cmd_t cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StRun  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            StIdle:
            begin
                s_tready       = sts.can_load;
                accept         = s_tvalid && sts.can_load;
                cmd.start_item = accept;
                if (accept && !sts.blocked)
                begin
                    if (sts.lit_pending)
                    begin
                        cmd.emit_lit = 1'b1;
                    end
                    else if (sts.bad_ctrl)
                    begin
                        cmd.set_err = 1'b1;
                    end
                    else
                    begin
                        cmd.take_ctrl = 1'b1;
                        if (sts.zero_run)
                        begin
                            state_next = StRun;
                        end
                    end
                end
            end
            StRun:
            begin
                cmd.emit_zero = sts.can_load;
                if (sts.can_load && sts.run_end)
                begin
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // no input word taken while a zero run is going out
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StRun) |-> !s_tready)
        else $error("input accepted during zero run");

    // a zero run is entered only after a control byte that asks for zeros
    a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg) |-> $past(cmd.take_ctrl && sts.zero_run))
        else $error("zero run entered without a control byte");

    // only one kind of action per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.emit_lit, cmd.set_err, cmd.take_ctrl, cmd.emit_zero}) <= 1)
        else $error("conflicting datapath commands");
`endif

endmodule

// ===== rtl/core/rlcd_dp.sv =====
// datapath for the run-length decoder: counters, limit register and output register
module rlcd_dp
    import rlcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CountW-1:0] cfg_wdata,
    input  logic [CodeW-1:0]  code_byte,
    input  logic              record_start,
    input  rlcd_cmd_t         cmd,
    output rlcd_sts_t         sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [CodeW-1:0]  data_byte,
    output logic              run_last,
    output logic [CountW-1:0] decoded_count,
    output logic              limit_reached,
    output logic              format_error
);

    logic [CountW-1:0] limit_reg,  limit_next;
    logic [LitW-1:0]   lit_reg,    lit_next;
    logic [CountW-1:0] prod_reg,   prod_next;
    logic              err_reg,    err_next;
    logic [LitW-1:0]   zl_reg,     zl_next;
    logic              ovalid_reg, ovalid_next;
    logic [CodeW-1:0]  odata_reg;
    logic              olast_reg;
    logic [CountW-1:0] ocount_reg;
    logic              olim_reg;
    logic              oerr_reg;

    logic              clear;
    logic [LitW-1:0]   lit_eff;
    logic [CountW-1:0] prod_eff;
    logic              err_eff;
    logic [CountW-1:0] prod_inc;
    logic [LitW-1:0]   ctl_zeros;
    logic [LitW-1:0]   ctl_lits;
    logic              load;

    assign clear    = cmd.start_item && record_start;
    assign lit_eff  = clear ? '0 : lit_reg;
    assign prod_eff = clear ? '0 : prod_reg;
    assign err_eff  = clear ? 1'b0 : err_reg;
    assign prod_inc = prod_eff + CountW'(1);
    assign load     = cmd.emit_lit || cmd.emit_zero;

    // control byte decode
    always_comb
    begin
        if (code_byte[CtlLongBit])
        begin
            ctl_zeros = {3'b000, code_byte[6:4]};
            ctl_lits  = {2'b00, code_byte[3:0]};
        end
        else if (code_byte[CtlShortBit])
        begin
            ctl_zeros = code_byte[5:0];
            ctl_lits  = '0;
        end
        else
        begin
            ctl_zeros = '0;
            ctl_lits  = code_byte[5:0];
        end
    end

    always_comb
    begin
        sts.can_load    = !ovalid_reg || m_tready;
        sts.blocked     = (prod_eff >= limit_reg);
        sts.lit_pending = (lit_eff != '0);
        sts.bad_ctrl    = (code_byte[6:0] == 7'd0);
        sts.zero_run    = (ctl_zeros != '0);
        sts.run_end     = (zl_reg == LitW'(1)) || (prod_inc >= limit_reg);
    end

    always_comb
    begin
        limit_next  = cfg_we ? cfg_wdata : limit_reg;
        lit_next    = cmd.take_ctrl ? ctl_lits :
                      (cmd.emit_lit ? lit_eff - LitW'(1) : lit_eff);
        prod_next   = load ? prod_inc : prod_eff;
        err_next    = cmd.set_err || err_eff;
        zl_next     = cmd.take_ctrl ? ctl_zeros :
                      (cmd.emit_zero ? zl_reg - LitW'(1) : zl_reg);
        ovalid_next = load || (ovalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LimitReset;
            lit_reg    <= '0;
            prod_reg   <= '0;
            err_reg    <= 1'b0;
            zl_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            limit_reg  <= limit_next;
            lit_reg    <= lit_next;
            prod_reg   <= prod_next;
            err_reg    <= err_next;
            zl_reg     <= zl_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            odata_reg  <= cmd.emit_lit ? code_byte : '0;
            olast_reg  <= cmd.emit_lit || sts.run_end;
            ocount_reg <= prod_inc;
            olim_reg   <= (prod_inc >= limit_reg);
            oerr_reg   <= err_eff;
        end
    end

    assign m_tvalid      = ovalid_reg;
    assign data_byte     = odata_reg;
    assign run_last      = olast_reg;
    assign decoded_count = ocount_reg;
    assign limit_reached = olim_reg;
    assign format_error  = oerr_reg;

`ifndef SYNTHESIS
    // a word is written to the output register only when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!ovalid_reg || m_tready))
        else $error("output register overwritten");

    // each zero fill word advances the count by exactly one
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_zero |=> (prod_reg == $past(prod_reg) + CountW'(1)))
        else $error("count did not advance on zero fill");

    // a control byte asking for zeros leaves a nonzero run length
    a_run_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_ctrl && sts.zero_run) |=> (zl_reg != '0))
        else $error("zero run length not loaded");
`endif

endmodule

// ===== rtl/core/zero_run_literal_rlc_decoder.sv =====
// top level of the zero-run / literal run-length decoder
// a literal word is registered and shows on the output in the cycle after it is taken
// throughput: one literal word per cycle while the output accepts; after a control byte
// with zeros, the zero fill is sent from the run counter one word a cycle on the same
// terms, with input held off; control bytes without zeros, malformed bytes and words
// past the limit emit no word; reset (rst_n, asynchronous, active low) clears all
// counters, the error flag and the output valid, and sets the output limit to 65535
module zero_run_literal_rlc_decoder
    import rlcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: output limit
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // coded input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // code_byte
    input  logic        s_tuser,    // record_start
    // decoded output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // data_byte [7:0], decoded_count [23:8]
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser     // limit_reached [0], format_error [1]
);

    rlcd_cmd_t         cmd;
    rlcd_sts_t         sts;
    logic [CodeW-1:0]  data_byte;
    logic [CountW-1:0] decoded_count;
    logic              limit_reached;
    logic              format_error;

    // controller: idle takes one word at a time, run sends the zero fill
    rlcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: literal and zero counters, record total, sticky error, output register
    rlcd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .code_byte     (s_tdata),
        .record_start  (s_tuser),
        .cmd           (cmd),
        .sts           (sts),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .data_byte     (data_byte),
        .run_last      (m_tlast),
        .decoded_count (decoded_count),
        .limit_reached (limit_reached),
        .format_error  (format_error)
    );

    // pack output fields, lowest field first
    assign m_tdata = {decoded_count, data_byte};
    assign m_tuser = {format_error, limit_reached};

endmodule
